FILE: sv/dpf_pkg.sv
// Shared constants for the duplicate packet filter.
package dpf_pkg;

    // Default number of source rows.
    localparam int DPF_NUM_SOURCES = 256;
    // Default number of sequence numbers kept per source.
    localparam int DPF_HIST = 8;
    // Width of the source index field.
    localparam int DPF_SRC_W = 8;
    // Number of distinct source index values.
    localparam int DPF_SRC_VALUES = 1 << DPF_SRC_W;
    // Width of a sequence number.
    localparam int DPF_SEQ_W = 32;

endpackage

FILE: sv/dpf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read take effect at the clock edge; read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/dpf_row_update.sv
// Compares a sequence number against one history row and builds the updated row.
module dpf_row_update import dpf_pkg::*; #(
    parameter int HIST = DPF_HIST
) (
    input  logic [HIST*DPF_SEQ_W + $clog2(HIST+1) + (HIST > 1 ? $clog2(HIST) : 1)-1:0] i_row,
    input  logic [DPF_SEQ_W-1:0] i_seq,
    output logic                 o_hit,
    output logic [HIST*DPF_SEQ_W + $clog2(HIST+1) + (HIST > 1 ? $clog2(HIST) : 1)-1:0] o_row
);

    localparam int FCW   = $clog2(HIST + 1);
    localparam int OSW   = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int SLOTW = HIST * DPF_SEQ_W;

    logic [FCW-1:0]       w_fill;
    logic [OSW-1:0]       w_oldest;
    logic                 w_full;
    logic [OSW-1:0]       w_wr_idx;
    logic [HIST-1:0]      w_match;
    logic [FCW-1:0]       w_next_fill;
    logic [OSW-1:0]       w_next_oldest;
    logic [SLOTW-1:0]     w_next_slots;

    assign w_fill   = i_row[SLOTW +: FCW];
    assign w_oldest = i_row[SLOTW + FCW +: OSW];
    assign w_full   = (w_fill == FCW'(HIST));

    // One compare per slot; only slots below the fill count take part.
    always_comb begin
        for (int k = 0; k < HIST; k++) begin
            w_match[k] = (FCW'(k) < w_fill) && (i_row[k*DPF_SEQ_W +: DPF_SEQ_W] == i_seq);
        end
    end

    assign o_hit = |w_match;

    // A new number goes to the next free slot, or over the oldest once the row is full.
    assign w_wr_idx = w_full ? w_oldest : w_fill[OSW-1:0];

    always_comb begin
        for (int k = 0; k < HIST; k++) begin
            w_next_slots[k*DPF_SEQ_W +: DPF_SEQ_W] = (w_wr_idx == OSW'(k)) ?
                i_seq : i_row[k*DPF_SEQ_W +: DPF_SEQ_W];
        end
    end

    // Fill count grows until the row is full; after that the oldest pointer rotates.
    always_comb begin
        w_next_fill   = w_fill;
        w_next_oldest = w_oldest;
        if (w_full) begin
            if (w_oldest == OSW'(HIST - 1)) begin
                w_next_oldest = '0;
            end else begin
                w_next_oldest = w_oldest + OSW'(1);
            end
        end else begin
            w_next_fill = w_fill + FCW'(1);
        end
    end

    assign o_row = {w_next_oldest, w_next_fill, w_next_slots};

endmodule

FILE: sv/duplicate_packet_filter_core.sv
// Top level of the per-source sequence-number duplicate filter.
// After reset the block runs a clearing pass over its row memory with o_in_ready low.
// Then each packet beat reads the source's history row from the row memory, compares the
// sequence number against the held numbers (up to HIST) at once and, for a new number,
// writes the updated row back, waiting while an earlier result is uncollected; that
// single read-modify-write of the row memory sets the rate. The result sits in an output
// register, so the next packet is taken while the previous result waits to be collected.
// A source index at or above NUM_SOURCES wraps onto row source_id modulo NUM_SOURCES.
module duplicate_packet_filter_core import dpf_pkg::*; #(
    parameter int NUM_SOURCES = DPF_NUM_SOURCES,
    parameter int HIST        = DPF_HIST
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [DPF_SRC_W-1:0] i_source_id,
    input  logic [DPF_SEQ_W-1:0] i_seq_number,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_is_new
);

    localparam int RW   = $clog2(NUM_SOURCES);
    localparam int FCW  = $clog2(HIST + 1);
    localparam int OSW  = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int ROWW = HIST * DPF_SEQ_W + FCW + OSW;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [RW-1:0]        r_clr_addr, n_clr_addr;
    logic [RW-1:0]        r_row;
    logic [DPF_SEQ_W-1:0] r_seq;
    logic                 r_out_valid, n_out_valid;
    logic                 r_is_new, n_is_new;

    logic [RW-1:0]        w_row_lut [DPF_SRC_VALUES];
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_finish;
    logic                 w_hit;
    logic [ROWW-1:0]      w_rd_row;
    logic [ROWW-1:0]      w_upd_row;
    logic                 w_wr_en;
    logic [RW-1:0]        w_wr_addr;
    logic [ROWW-1:0]      w_wr_data;

    // Source index to row number, worked out for every index at elaboration.
    for (genvar g = 0; g < DPF_SRC_VALUES; g++) begin : g_row_lut
        assign w_row_lut[g] = RW'(g % NUM_SOURCES);
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == S_LOOK) && w_out_free;

    // Row memory: history slots, fill count and oldest pointer of each source.
    dpf_ram #(
        .WIDTH (ROWW),
        .DEPTH (NUM_SOURCES)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_row_lut[i_source_id]),
        .o_rd_data (w_rd_row)
    );

    // Compare and update of the row just read.
    dpf_row_update #(
        .HIST (HIST)
    ) u_row_update (
        .i_row (w_rd_row),
        .i_seq (r_seq),
        .o_hit (w_hit),
        .o_row (w_upd_row)
    );

    // Write port: zero rows during the clearing pass, updated row for a new number.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_row;
        w_wr_data = w_upd_row;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else if (w_finish && !w_hit) begin
            w_wr_en = 1'b1;
        end
    end

    // Sequencer and output register.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_is_new    = r_is_new;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == RW'(NUM_SOURCES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + RW'(1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_is_new    = !w_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_is_new <= n_is_new;
        if (w_accept) begin
            r_row <= w_row_lut[i_source_id];
            r_seq <= i_seq_number;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_new    = r_is_new;

    // An accepted beat always moves on to the row compare.
    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("accepted beat did not enter the compare state");

    // A result only appears right after a row compare.
    a_result_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_LOOK))
        else $error("result raised without a row compare");

    // No input is taken and no result is pending during the clearing pass.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_in_ready && !r_out_valid))
        else $error("activity during clearing pass");

    // A row read back never claims more entries than it holds.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> (w_rd_row[HIST*DPF_SEQ_W +: FCW] <= FCW'(HIST)))
        else $error("fill count above history depth");

endmodule
